// ===== design/lfps_pkg.sv =====
`default_nettype none

package lfps_pkg;

  // field widths
  localparam int SampleBits = 10;
  localparam int SpeedW     = 16;
  localparam int GainW      = 8;
  localparam int ErrW       = SampleBits + 1;   // signed side error, also the running sum
  localparam int DiffW      = SampleBits + 2;   // signed error difference
  localparam int SumLimit   = 600;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_LEFT_BLACK  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_BLACK = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BASELINE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_SPEED   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEED   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN  = 3'd7;

  // queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // floor(x / 10) for 16-bit x as (x * 52429) >> 19
  localparam int Div10Mult  = 52429;
  localparam int Div10Shift = 19;
  localparam int Div10W     = 2 * SpeedW - Div10Shift;

  typedef enum logic [1:0] {
    SIDE_CENTER = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_LEFT   = 2'd2
  } side_t;

  typedef struct packed {
    logic [SampleBits-1:0] left_black;
    logic [SampleBits-1:0] right_black;
    logic [SampleBits-1:0] baseline;
  } front_cfg_t;

  typedef struct packed {
    logic [SpeedW-1:0] base_speed;
    logic [SpeedW-1:0] speed_cap;
    logic [SpeedW-1:0] speed_floor;
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  deriv_gain;
  } back_cfg_t;

  // one classified step handed from front to back
  typedef struct packed {
    side_t                  side;
    logic signed [ErrW-1:0]  err;
    logic signed [DiffW-1:0] diff;
    logic signed [ErrW-1:0]  half_sum;
    logic [SampleBits-1:0]   left_dev;
    logic [SampleBits-1:0]   right_dev;
  } step_t;

endpackage

`default_nettype wire

// ===== design/lfps_front.sv =====
`default_nettype none

module lfps_front import lfps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SampleBits-1:0] left_sample,
  input  wire logic [SampleBits-1:0] right_sample,
  input  wire front_cfg_t            cfg,
  input  wire logic                  q_full,
  output logic                       push,
  output step_t                      push_data
);

  localparam logic signed [DiffW-1:0] SumHi = DiffW'(SumLimit);
  localparam logic signed [DiffW-1:0] SumLo = -SumHi;

  side_t                   side_state;
  side_t                   side_next;
  logic signed [ErrW-1:0]  last_error;
  logic signed [ErrW-1:0]  error_sum;
  logic signed [ErrW-1:0]  error_sum_next;
  logic [SampleBits-1:0]   left_dev;
  logic [SampleBits-1:0]   right_dev;
  logic signed [ErrW-1:0]  err;
  logic signed [DiffW-1:0] diff;
  logic signed [ErrW-1:0]  half_sum;
  logic signed [DiffW-1:0] sum_wide;
  logic                    accept;

  // black level minus sample, less the dead band, floored at zero
  function automatic logic [SampleBits-1:0] side_error(
    input logic [SampleBits-1:0] black,
    input logic [SampleBits-1:0] sample,
    input logic [SampleBits-1:0] base
  );
    logic signed [SampleBits:0] raw;
    logic signed [SampleBits:0] dead;
    logic signed [SampleBits:0] rem;
    raw  = $signed({1'b0, black}) - $signed({1'b0, sample});
    dead = $signed({1'b0, base});
    rem  = raw - dead;
    if (raw > dead) begin
      return rem[SampleBits-1:0];
    end else begin
      return '0;
    end
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  always_comb begin
    left_dev  = side_error(cfg.left_black, left_sample, cfg.baseline);
    right_dev = side_error(cfg.right_black, right_sample, cfg.baseline);

    priority if (left_dev == '0 && right_dev == '0) begin
      side_next = SIDE_CENTER;
    end else if (left_dev == '0) begin
      side_next = SIDE_RIGHT;
    end else if (right_dev == '0) begin
      side_next = SIDE_LEFT;
    end else begin
      side_next = side_state;
    end

    unique case (side_next)
      SIDE_RIGHT: err = $signed({1'b0, right_dev});
      SIDE_LEFT:  err = -$signed({1'b0, left_dev});
      default:    err = '0;
    endcase

    diff = DiffW'(err) - DiffW'(last_error);

    // halving that truncates toward zero
    half_sum = (error_sum >>> 1)
             + $signed({{(ErrW-1){1'b0}}, error_sum[ErrW-1] & error_sum[0]});

    sum_wide = DiffW'(error_sum) + DiffW'(err);
    priority if (sum_wide > SumHi) begin
      error_sum_next = ErrW'(SumHi);
    end else if (sum_wide < SumLo) begin
      error_sum_next = ErrW'(SumLo);
    end else begin
      error_sum_next = ErrW'(sum_wide);
    end

    push_data.side      = side_next;
    push_data.err       = err;
    push_data.diff      = diff;
    push_data.half_sum  = half_sum;
    push_data.left_dev  = left_dev;
    push_data.right_dev = right_dev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_state <= SIDE_CENTER;
      last_error <= '0;
      error_sum  <= '0;
    end else if (accept) begin
      side_state <= side_next;
      last_error <= err;
      error_sum  <= error_sum_next;
    end
  end

`ifndef SYNTHESIS
  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (error_sum <= SumLimit && error_sum >= -SumLimit))
    else $error("running error sum left its limit");
`endif

endmodule

`default_nettype wire

// ===== design/lfps_queue.sv =====
`default_nettype none

module lfps_queue import lfps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire step_t push_data,
  input  wire logic  pop,
  output logic       full,
  output logic       q_valid,
  output step_t      head
);

  step_t             entries [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  assign full    = (count == QCntW'(QueueDepth));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/lfps_back.sv =====
`default_nettype none

module lfps_back import lfps_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire step_t            head,
  output logic                  pop,
  input  wire back_cfg_t        cfg,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SpeedW-1:0]     left_drive,
  output logic [SpeedW-1:0]     right_drive,
  output logic [1:0]            side_seen,
  output logic [SampleBits-1:0] left_error_out,
  output logic [SampleBits-1:0] right_error_out
);

  localparam int PW  = ErrW + GainW + 1;   // prop product
  localparam int DW  = DiffW + GainW + 1;  // deriv product
  localparam int MW  = DW + 1;             // correction
  localparam int MEW = MW + 1;             // correction, doubled on left
  localparam int VW  = MEW + 2;            // raw wheel level

  logic en1, en2, en3;

  // stage 1: products
  logic                   s1_valid;
  side_t                  s1_side;
  logic signed [PW-1:0]   s1_p;
  logic signed [DW-1:0]   s1_d;
  logic signed [ErrW-1:0] s1_half;
  logic [SampleBits-1:0]  s1_lerr, s1_rerr;
  logic [Div10W-1:0]      s1_div10;
  logic signed [PW-1:0]   p_mult;
  logic signed [DW-1:0]   d_mult;
  logic [2*SpeedW-1:0]    div_prod;

  // stage 2: correction and left overshoot level
  logic                   s2_valid;
  side_t                  s2_side;
  logic signed [MEW-1:0]  s2_m;
  logic [SpeedW-1:0]      s2_ovr;
  logic [SampleBits-1:0]  s2_lerr, s2_rerr;
  logic signed [MW-1:0]   m_sum;
  logic signed [MEW-1:0]  m_eff;
  logic [SpeedW:0]        ovr_sum;
  logic [SpeedW-1:0]      ovr_sat;

  logic signed [VW-1:0]   ls, rs;
  logic [SpeedW-1:0]      ls_clamped, rs_clamped;

  function automatic logic [SpeedW-1:0] clamp_drive(
    input logic signed [VW-1:0] v,
    input logic [SpeedW-1:0]    hi_val,
    input logic [SpeedW-1:0]    mx,
    input logic [SpeedW-1:0]    mn
  );
    logic signed [VW-1:0] t;
    if (v > $signed(VW'(mx))) begin
      t = $signed(VW'(hi_val));
    end else begin
      t = v;
    end
    if (t < $signed(VW'(mn))) begin
      t = $signed(VW'(mn));
    end
    return t[SpeedW-1:0];
  endfunction

  assign en3 = !out_valid || out_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign pop = q_valid && en1;

  always_comb begin
    p_mult   = $signed({1'b0, cfg.prop_gain}) * $signed(head.err);
    d_mult   = $signed({1'b0, cfg.deriv_gain}) * $signed(head.diff);
    div_prod = cfg.speed_cap * SpeedW'(Div10Mult);

    m_sum = MW'(s1_p) + MW'(s1_d) + MW'(s1_half);
    unique case (s1_side)
      SIDE_LEFT:  m_eff = MEW'(m_sum) <<< 1;
      SIDE_RIGHT: m_eff = MEW'(m_sum);
      default:    m_eff = '0;
    endcase
    // floor(max * 11 / 10) as max + floor(max / 10), saturated
    ovr_sum = {1'b0, cfg.speed_cap} + (SpeedW+1)'(s1_div10);
    ovr_sat = ovr_sum[SpeedW] ? '1 : ovr_sum[SpeedW-1:0];

    ls = $signed(VW'(cfg.base_speed)) - VW'(s2_m);
    rs = $signed(VW'(cfg.base_speed)) + VW'(s2_m);
    ls_clamped = clamp_drive(ls, s2_ovr, cfg.speed_cap, cfg.speed_floor);
    rs_clamped = clamp_drive(rs, cfg.speed_cap, cfg.speed_cap, cfg.speed_floor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= q_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_side  <= head.side;
      s1_p     <= p_mult;
      s1_d     <= d_mult;
      s1_half  <= head.half_sum;
      s1_lerr  <= head.left_dev;
      s1_rerr  <= head.right_dev;
      s1_div10 <= div_prod[2*SpeedW-1:Div10Shift];
    end
    if (en2) begin
      s2_side <= s1_side;
      s2_m    <= m_eff;
      s2_ovr  <= ovr_sat;
      s2_lerr <= s1_lerr;
      s2_rerr <= s1_rerr;
    end
    if (en3) begin
      left_drive      <= ls_clamped;
      right_drive     <= rs_clamped;
      side_seen       <= s2_side;
      left_error_out  <= s2_lerr;
      right_error_out <= s2_rerr;
    end
  end

`ifndef SYNTHESIS
  a_drive_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive >= cfg.speed_floor && right_drive >= cfg.speed_floor))
    else $error("drive below min level");
`endif

endmodule

`default_nettype wire

// ===== design/line_follow_pid_steer.sv =====
// channel   signals                                   direction
// in        in_valid in_ready left_sample right_sample  sensor pair in
// out       out_valid out_ready left_drive right_drive  drive pair out
//           side_seen left_error_out right_error_out
// cfg       cfg_valid cfg_ready cfg_index cfg_data      register write in
//
// one sample pair per clock sustained while out_ready holds high; a result passes the queue
// write, product stage, correction stage and output register after its beat is taken
// the side, last error and clamped sum recurrence closes in the front, updated on each taken beat
// a two-beat queue lets the front keep taking beats while the back stalls on out_ready, until it fills
// cfg_ready is always high; registers return to their reset values on rst
`default_nettype none

module line_follow_pid_steer import lfps_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SampleBits-1:0] left_sample,
  input  wire logic [SampleBits-1:0] right_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SpeedW-1:0]          left_drive,
  output logic [SpeedW-1:0]          right_drive,
  output logic [1:0]                 side_seen,
  output logic [SampleBits-1:0]      left_error_out,
  output logic [SampleBits-1:0]      right_error_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data
);

  front_cfg_t front_cfg;
  back_cfg_t  back_cfg;

  // handoff between front and back
  logic  push;
  step_t push_data;
  logic  pop;
  logic  q_full;
  logic  q_valid;
  step_t head;

  // config writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg.left_black  <= '1;
      front_cfg.right_black <= '1;
      front_cfg.baseline    <= '0;
      back_cfg.base_speed   <= '0;
      back_cfg.speed_cap    <= '0;
      back_cfg.speed_floor  <= '0;
      back_cfg.prop_gain    <= GainW'(3);
      back_cfg.deriv_gain   <= GainW'(25);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT_BLACK:  front_cfg.left_black  <= cfg_data[SampleBits-1:0];
        REG_RIGHT_BLACK: front_cfg.right_black <= cfg_data[SampleBits-1:0];
        REG_BASELINE:    front_cfg.baseline    <= cfg_data[SampleBits-1:0];
        REG_BASE_SPEED:  back_cfg.base_speed   <= cfg_data[SpeedW-1:0];
        REG_MAX_SPEED:   back_cfg.speed_cap    <= cfg_data[SpeedW-1:0];
        REG_MIN_SPEED:   back_cfg.speed_floor  <= cfg_data[SpeedW-1:0];
        REG_PROP_GAIN:   back_cfg.prop_gain    <= cfg_data[GainW-1:0];
        REG_DERIV_GAIN:  back_cfg.deriv_gain   <= cfg_data[GainW-1:0];
        default:         ;
      endcase
    end
  end

  // front: side errors, side tracking, pid state update
  lfps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .cfg          (front_cfg),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  // two-beat queue decouples the stall domains
  lfps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head)
  );

  // back: gains, steering, clamps, output register
  lfps_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .cfg             (back_cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .left_drive      (left_drive),
    .right_drive     (right_drive),
    .side_seen       (side_seen),
    .left_error_out  (left_error_out),
    .right_error_out (right_error_out)
  );

endmodule

`default_nettype wire
